// ----- src/ecss_pkg.sv -----
// shared types, constants and register codes for the echo distance safety stop
`default_nettype none

package ecss_pkg;

    localparam int COUNT_CAP_DEFAULT = 20;

    localparam int OPCODE_W  = 1;
    localparam int WIDTH_US_W = 16;
    localparam int DIST_W    = 12;
    localparam int CONFIRM_W = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 12;

    // width * 343 / 2000 done as width * DIST_MUL >> DIST_SHIFT, exact for 16-bit widths
    localparam int DIST_MUL_W  = 25;
    localparam int DIST_SHIFT  = 27;
    localparam int DIST_PROD_W = WIDTH_US_W + DIST_MUL_W;
    localparam int DIST_FULL_W = DIST_PROD_W - DIST_SHIFT;
    localparam logic [DIST_MUL_W-1:0] DIST_MUL = 25'd23018341;

    localparam logic [DIST_FULL_W-1:0] DIST_LO_MM = 14'd190;
    localparam logic [DIST_FULL_W-1:0] DIST_HI_MM = 14'd4000;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ECHO    = 1'b0,
        OP_TIMEOUT = 1'b1
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SENSOR_ENABLED  = 3'd0,
        REG_WARN_DISTANCE   = 3'd1,
        REG_STOP_DISTANCE   = 3'd2,
        REG_EMERG_DISTANCE  = 3'd3,
        REG_CLEAR_MARGIN    = 3'd4,
        REG_DANGER_CONFIRM  = 3'd5,
        REG_CLEAR_CONFIRM   = 3'd6
    } reg_index_t;

    localparam logic                 RST_SENSOR_ENABLED = 1'b1;
    localparam logic [DIST_W-1:0]    RST_WARN_DISTANCE  = 12'd600;
    localparam logic [DIST_W-1:0]    RST_STOP_DISTANCE  = 12'd350;
    localparam logic [DIST_W-1:0]    RST_EMERG_DISTANCE = 12'd250;
    localparam logic [DIST_W-1:0]    RST_CLEAR_MARGIN   = 12'd150;
    localparam logic [CONFIRM_W-1:0] RST_DANGER_CONFIRM = 8'd2;
    localparam logic [CONFIRM_W-1:0] RST_CLEAR_CONFIRM  = 8'd3;

endpackage

`default_nettype wire

// ----- src/ecss_item_if.sv -----
// input word channel: one echo event
`default_nettype none

interface ecss_item_if;
    logic                               valid;
    logic                               ready;
    logic [ecss_pkg::OPCODE_W-1:0]      opcode;
    logic [ecss_pkg::WIDTH_US_W-1:0]    echo_width_us;
    logic                               system_armed;

    modport source (output valid, output opcode, output echo_width_us,
                    output system_armed, input ready);
    modport sink   (input valid, input opcode, input echo_width_us,
                    input system_armed, output ready);
endinterface

`default_nettype wire

// ----- src/ecss_result_if.sv -----
// result word channel: distance and safety flags
`default_nettype none

interface ecss_result_if;
    logic                           valid;
    logic                           ready;
    logic [ecss_pkg::DIST_W-1:0]    distance_mm;
    logic                           reading_valid;
    logic                           near_flag;
    logic                           stop_flag;
    logic                           emergency_flag;
    logic                           disarm_request;
    logic                           stop_event;

    modport source (output valid, output distance_mm, output reading_valid,
                    output near_flag, output stop_flag, output emergency_flag,
                    output disarm_request, output stop_event, input ready);
    modport sink   (input valid, input distance_mm, input reading_valid,
                    input near_flag, input stop_flag, input emergency_flag,
                    input disarm_request, input stop_event, output ready);
endinterface

`default_nettype wire

// ----- src/ecss_cfg_if.sv -----
// configuration write channel: register index and data word
`default_nettype none

interface ecss_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [ecss_pkg::CFG_IDX_W-1:0]     index;
    logic [ecss_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- src/echo_distance_safety_stop_unit.sv -----
// echo distance safety stop: distance conversion, confirm counters and stop latch
//
//  channel     dir  handshake     word
//  cfg         in   valid/ready   index, data (always ready)
//  item_in     in   valid/ready   opcode, echo_width_us, system_armed
//  result_out  out  valid/ready   distance_mm, flags, disarm_request, stop_event
//
//  one word per cycle sustained unless result_out stalls; each word passes the stages in order
//  stages: input register, distance multiply register, safety state and result register
//  all stages advance together when the result register is empty or being taken
//  item_in.ready is the shared advance signal; a stalled result holds the whole pipe
//  rst_n clears pipe valids, safety state and loads register defaults
`default_nettype none

module echo_distance_safety_stop_unit #(
    parameter int COUNT_CAP = ecss_pkg::COUNT_CAP_DEFAULT
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    ecss_cfg_if.sink      cfg,
    ecss_item_if.sink     item_in,
    ecss_result_if.source result_out
);

    localparam int COUNT_W = $clog2(COUNT_CAP + 1);
    localparam int DW  = ecss_pkg::DIST_W;
    localparam int DFW = ecss_pkg::DIST_FULL_W;
    localparam int CW  = ecss_pkg::CONFIRM_W;

    // configuration
    logic           sensor_enabled_reg;
    logic [DW-1:0]  warn_distance_reg;
    logic [DW-1:0]  stop_distance_reg;
    logic [DW-1:0]  emerg_distance_reg;
    logic [DW-1:0]  clear_margin_reg;
    logic [CW-1:0]  danger_confirm_reg;
    logic [CW-1:0]  clear_confirm_reg;

    // pipe
    logic                               advance;
    logic                               s1_valid_reg;
    logic [ecss_pkg::OPCODE_W-1:0]      s1_opcode_reg;
    logic [ecss_pkg::WIDTH_US_W-1:0]    s1_width_reg;
    logic                               s1_armed_reg;
    logic [ecss_pkg::DIST_PROD_W-1:0]   s1_prod;
    logic                               s2_valid_reg;
    logic [ecss_pkg::OPCODE_W-1:0]      s2_opcode_reg;
    logic [DFW-1:0]                     s2_dist_reg;
    logic                               s2_armed_reg;
    logic                               out_valid_reg;

    // safety state
    logic [COUNT_W-1:0] danger_count_reg, danger_count_next;
    logic [COUNT_W-1:0] clear_count_reg, clear_count_next;
    logic               stop_reg, stop_next;
    logic               emerg_reg, emerg_next;
    logic               rvalid_reg, rvalid_next;
    logic               near_reg, near_next;
    logic               reported_reg, reported_next;
    logic [DW-1:0]      last_dist_reg, last_dist_next;
    logic               disarm_reg, disarm_next;
    logic               event_reg, event_next;

    logic               sample_ok;
    logic [DW:0]        clear_level;
    logic [COUNT_W:0]   danger_inc;
    logic [COUNT_W:0]   clear_inc;
    logic [COUNT_W-1:0] danger_sat;
    logic [COUNT_W-1:0] clear_sat;

    // config writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sensor_enabled_reg <= ecss_pkg::RST_SENSOR_ENABLED;
            warn_distance_reg  <= ecss_pkg::RST_WARN_DISTANCE;
            stop_distance_reg  <= ecss_pkg::RST_STOP_DISTANCE;
            emerg_distance_reg <= ecss_pkg::RST_EMERG_DISTANCE;
            clear_margin_reg   <= ecss_pkg::RST_CLEAR_MARGIN;
            danger_confirm_reg <= ecss_pkg::RST_DANGER_CONFIRM;
            clear_confirm_reg  <= ecss_pkg::RST_CLEAR_CONFIRM;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                ecss_pkg::REG_SENSOR_ENABLED: sensor_enabled_reg <= cfg.data[0];
                ecss_pkg::REG_WARN_DISTANCE:  warn_distance_reg  <= cfg.data[DW-1:0];
                ecss_pkg::REG_STOP_DISTANCE:  stop_distance_reg  <= cfg.data[DW-1:0];
                ecss_pkg::REG_EMERG_DISTANCE: emerg_distance_reg <= cfg.data[DW-1:0];
                ecss_pkg::REG_CLEAR_MARGIN:   clear_margin_reg   <= cfg.data[DW-1:0];
                ecss_pkg::REG_DANGER_CONFIRM: danger_confirm_reg <= cfg.data[CW-1:0];
                ecss_pkg::REG_CLEAR_CONFIRM:  clear_confirm_reg  <= cfg.data[CW-1:0];
                default: ;
            endcase
        end
    end

    // pipe control
    assign advance       = !out_valid_reg || result_out.ready;
    assign item_in.ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= item_in.valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    // distance in mm via reciprocal multiply
    assign s1_prod = ecss_pkg::DIST_PROD_W'(s1_width_reg) *
                     ecss_pkg::DIST_PROD_W'(ecss_pkg::DIST_MUL);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_opcode_reg <= item_in.opcode;
            s1_width_reg  <= item_in.echo_width_us;
            s1_armed_reg  <= item_in.system_armed;
            s2_opcode_reg <= s1_opcode_reg;
            s2_dist_reg   <= s1_prod[ecss_pkg::DIST_PROD_W-1:ecss_pkg::DIST_SHIFT];
            s2_armed_reg  <= s1_armed_reg;
        end
    end

    // safety state update
    assign sample_ok = (s2_opcode_reg == ecss_pkg::OP_ECHO) &&
                       (s2_dist_reg >= ecss_pkg::DIST_LO_MM) &&
                       (s2_dist_reg <= ecss_pkg::DIST_HI_MM);
    assign clear_level = (DW + 1)'(stop_distance_reg) + (DW + 1)'(clear_margin_reg);

    assign danger_inc = (COUNT_W + 1)'(danger_count_reg) + (COUNT_W + 1)'(1);
    assign clear_inc  = (COUNT_W + 1)'(clear_count_reg) + (COUNT_W + 1)'(1);
    assign danger_sat = (danger_inc >= (COUNT_W + 1)'(COUNT_CAP)) ?
                        COUNT_W'(COUNT_CAP) : danger_inc[COUNT_W-1:0];
    assign clear_sat  = (clear_inc >= (COUNT_W + 1)'(COUNT_CAP)) ?
                        COUNT_W'(COUNT_CAP) : clear_inc[COUNT_W-1:0];

    always_comb
    begin
        danger_count_next = danger_count_reg;
        clear_count_next  = clear_count_reg;
        stop_next         = stop_reg;
        emerg_next        = emerg_reg;
        rvalid_next       = rvalid_reg;
        near_next         = near_reg;
        reported_next     = reported_reg;
        last_dist_next    = last_dist_reg;
        disarm_next       = 1'b0;
        event_next        = 1'b0;
        if (!sensor_enabled_reg)
        begin
            danger_count_next = '0;
            clear_count_next  = '0;
            stop_next         = 1'b0;
            emerg_next        = 1'b0;
            rvalid_next       = 1'b0;
            near_next         = 1'b0;
            reported_next     = 1'b0;
        end
        else if (!sample_ok)
        begin
            rvalid_next       = 1'b0;
            near_next         = 1'b0;
            danger_count_next = '0;
        end
        else
        begin
            rvalid_next    = 1'b1;
            last_dist_next = s2_dist_reg[DW-1:0];
            near_next      = s2_dist_reg <= DFW'(warn_distance_reg);
            if (s2_dist_reg <= DFW'(stop_distance_reg))
            begin
                danger_count_next = danger_sat;
                clear_count_next  = '0;
            end
            else if (s2_dist_reg > DFW'(clear_level))
            begin
                clear_count_next  = clear_sat;
                danger_count_next = '0;
            end
            if (CW'(danger_count_next) >= danger_confirm_reg)
            begin
                stop_next = 1'b1;
            end
            // release wins over set
            if (CW'(clear_count_next) >= clear_confirm_reg)
            begin
                stop_next     = 1'b0;
                reported_next = 1'b0;
            end
            emerg_next  = stop_next && (s2_dist_reg <= DFW'(emerg_distance_reg));
            disarm_next = stop_next && s2_armed_reg;
            if (stop_next && !reported_next)
            begin
                reported_next = 1'b1;
                event_next    = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            danger_count_reg <= '0;
            clear_count_reg  <= '0;
            stop_reg         <= 1'b0;
            emerg_reg        <= 1'b0;
            rvalid_reg       <= 1'b0;
            near_reg         <= 1'b0;
            reported_reg     <= 1'b0;
            last_dist_reg    <= '0;
            disarm_reg       <= 1'b0;
            event_reg        <= 1'b0;
        end
        else if (advance && s2_valid_reg)
        begin
            danger_count_reg <= danger_count_next;
            clear_count_reg  <= clear_count_next;
            stop_reg         <= stop_next;
            emerg_reg        <= emerg_next;
            rvalid_reg       <= rvalid_next;
            near_reg         <= near_next;
            reported_reg     <= reported_next;
            last_dist_reg    <= last_dist_next;
            disarm_reg       <= disarm_next;
            event_reg        <= event_next;
        end
    end

    // result word
    assign result_out.valid          = out_valid_reg;
    assign result_out.distance_mm    = last_dist_reg;
    assign result_out.reading_valid  = rvalid_reg;
    assign result_out.near_flag      = near_reg;
    assign result_out.stop_flag      = stop_reg;
    assign result_out.emergency_flag = emerg_reg;
    assign result_out.disarm_request = disarm_reg;
    assign result_out.stop_event     = event_reg;

`ifndef NO_ASSERTIONS
    a_counts_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !((danger_count_reg != '0) && (clear_count_reg != '0)))
        else $error("danger and clear counts both nonzero");

    a_event_needs_stop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && event_reg |-> stop_reg && reported_reg)
        else $error("stop event without latched stop");

    a_emerg_needs_stop: assert property (@(posedge clk) disable iff (!rst_n)
        emerg_reg |-> stop_reg)
        else $error("emergency without stop");

    a_disarm_on_valid: assert property (@(posedge clk) disable iff (!rst_n)
        disarm_reg |-> stop_reg && rvalid_reg)
        else $error("disarm request without valid stopped sample");

    a_near_on_valid: assert property (@(posedge clk) disable iff (!rst_n)
        near_reg |-> rvalid_reg)
        else $error("near flag on invalid sample");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result_out.ready |=> $stable(stop_reg) && $stable(event_reg)
            && $stable(last_dist_reg))
        else $error("result changed while stalled");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/echo_distance_safety_stop_unit_tb.sv -----
// testbench for the echo distance safety stop: echo words checked against a predictor
`default_nettype none

module echo_distance_safety_stop_unit_tb;

    localparam int DIST_W      = ecss_pkg::DIST_W;
    localparam int WIDTH_US_W  = ecss_pkg::WIDTH_US_W;
    localparam int CONFIRM_W   = ecss_pkg::CONFIRM_W;
    localparam int CFG_DATA_W  = ecss_pkg::CFG_DATA_W;
    localparam int LO_MM       = int'(ecss_pkg::DIST_LO_MM);
    localparam int HI_MM       = int'(ecss_pkg::DIST_HI_MM);
    localparam int SOUND_NUM   = 343;
    localparam int SOUND_DEN   = 2000;
    localparam int COUNT_CAP   = ecss_pkg::COUNT_CAP_DEFAULT;
    localparam int PHASE_WORDS = 150;
    localparam int CYCLE_LIMIT = 250000;

    typedef struct packed {
        ecss_pkg::opcode_t      op;
        logic [WIDTH_US_W-1:0]  width_us;
        logic                   armed;
    } echo_word_t;

    typedef struct packed {
        logic [DIST_W-1:0]  distance_mm;
        logic               reading_valid;
        logic               near_flag;
        logic               stop_flag;
        logic               emergency_flag;
        logic               disarm_request;
        logic               stop_event;
    } safety_report_t;

    logic clk = 1'b0;
    logic rst_n;

    ecss_cfg_if    cfg_bus ();
    ecss_item_if   item_bus ();
    ecss_result_if result_bus ();

    echo_distance_safety_stop_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_bus),
        .item_in    (item_bus),
        .result_out (result_bus)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // register shadow
    logic                  cfg_enabled;
    logic [DIST_W-1:0]     warn_mm;
    logic [DIST_W-1:0]     stop_mm;
    logic [DIST_W-1:0]     emerg_mm;
    logic [DIST_W-1:0]     margin_mm;
    logic [CONFIRM_W-1:0]  danger_need;
    logic [CONFIRM_W-1:0]  clear_need;

    // safety state of the predictor
    int                 danger_run;
    int                 clear_run;
    logic               stop_held;
    logic               emerg_held;
    logic               reading_ok;
    logic               near_held;
    logic               event_sent;
    logic [DIST_W-1:0]  last_mm;

    echo_word_t      echo_backlog[$];
    safety_report_t  predicted_reports[$];
    echo_word_t      next_echo;
    safety_report_t  seen_report;

    int mismatches = 0;
    int cycle_cnt  = 0;
    int burst_left;
    int gap_left;
    int stall_mode;
    int mode_left;
    logic [3:0] stall_tick;

    function automatic int sat_bump(int count);
        return (count + 1 >= COUNT_CAP) ? COUNT_CAP : count + 1;
    endfunction

    function automatic safety_report_t advance_safety(ecss_pkg::opcode_t op,
                                                      logic [WIDTH_US_W-1:0] width_us,
                                                      logic armed);
        safety_report_t rep;
        int mm;
        logic ok;
        rep = '0;
        if (!cfg_enabled)
        begin
            reading_ok = 1'b0;
            near_held  = 1'b0;
            stop_held  = 1'b0;
            emerg_held = 1'b0;
            danger_run = 0;
            clear_run  = 0;
            event_sent = 1'b0;
        end
        else
        begin
            mm = (int'(width_us) * SOUND_NUM) / SOUND_DEN;
            ok = (op == ecss_pkg::OP_ECHO) && mm >= LO_MM && mm <= HI_MM;
            reading_ok = ok;
            if (!ok)
            begin
                danger_run = 0;
                near_held  = 1'b0;
            end
            else
            begin
                last_mm   = mm[DIST_W-1:0];
                near_held = mm <= int'(warn_mm);
                if (mm <= int'(stop_mm))
                begin
                    danger_run = sat_bump(danger_run);
                    clear_run  = 0;
                end
                else if (mm > int'(stop_mm) + int'(margin_mm))
                begin
                    clear_run  = sat_bump(clear_run);
                    danger_run = 0;
                end
                if (danger_run >= int'(danger_need))
                    stop_held = 1'b1;
                // release wins when both counts reach their thresholds
                if (clear_run >= int'(clear_need))
                begin
                    stop_held  = 1'b0;
                    event_sent = 1'b0;
                end
                emerg_held         = stop_held && mm <= int'(emerg_mm);
                rep.disarm_request = stop_held && armed;
                if (stop_held && !event_sent)
                begin
                    event_sent     = 1'b1;
                    rep.stop_event = 1'b1;
                end
            end
        end
        rep.distance_mm    = last_mm;
        rep.reading_valid  = reading_ok;
        rep.near_flag      = near_held;
        rep.stop_flag      = stop_held;
        rep.emergency_flag = emerg_held;
        return rep;
    endfunction

    function automatic void check_field(string name, logic [DIST_W-1:0] want,
                                        logic [DIST_W-1:0] seen);
        if (seen !== want)
        begin
            $error("%s expected %0d got %0d", name, want, seen);
            mismatches++;
        end
    endfunction

    // driver: bursts of words with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_bus.valid         <= 1'b0;
            item_bus.opcode        <= ecss_pkg::OP_ECHO;
            item_bus.echo_width_us <= '0;
            item_bus.system_armed  <= 1'b0;
            burst_left             <= 0;
            gap_left               <= 0;
        end
        else
        begin
            if (item_bus.valid && item_bus.ready)
                predicted_reports.push_back(
                    advance_safety(ecss_pkg::opcode_t'(item_bus.opcode),
                                   item_bus.echo_width_us, item_bus.system_armed));
            if (!item_bus.valid || item_bus.ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left       <= gap_left - 1;
                    item_bus.valid <= 1'b0;
                end
                else if (echo_backlog.size() != 0)
                begin
                    next_echo = echo_backlog.pop_front();
                    item_bus.valid         <= 1'b1;
                    item_bus.opcode        <= next_echo.op;
                    item_bus.echo_width_us <= next_echo.width_us;
                    item_bus.system_armed  <= next_echo.armed;
                    if (burst_left <= 1)
                    begin
                        burst_left <= int'($urandom_range(1, 40));
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0
                                                                  : int'($urandom_range(1, 7));
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    item_bus.valid <= 1'b0;
            end
        end
    end

    // monitor: result stalls and checking
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_bus.ready <= 1'b0;
            stall_mode       <= 0;
            mode_left        <= 100;
            stall_tick       <= '0;
        end
        else
        begin
            stall_tick <= stall_tick + 1'b1;
            if (mode_left == 0)
            begin
                stall_mode <= int'($urandom_range(0, 3));
                mode_left  <= int'($urandom_range(32, 256));
            end
            else
                mode_left <= mode_left - 1;
            case (stall_mode)
                0:       result_bus.ready <= 1'b1;
                1:       result_bus.ready <= 1'($urandom_range(0, 1));
                2:       result_bus.ready <= ($urandom_range(0, 3) == 0);
                default: result_bus.ready <= (stall_tick >= 4'd10);
            endcase
            if (result_bus.valid && result_bus.ready)
            begin
                if (predicted_reports.size() == 0)
                begin
                    $error("result word with no prediction waiting");
                    mismatches++;
                end
                else
                begin
                    seen_report = predicted_reports.pop_front();
                    check_field("distance_mm", seen_report.distance_mm,
                                result_bus.distance_mm);
                    check_field("reading_valid", DIST_W'(seen_report.reading_valid),
                                DIST_W'(result_bus.reading_valid));
                    check_field("near_flag", DIST_W'(seen_report.near_flag),
                                DIST_W'(result_bus.near_flag));
                    check_field("stop_flag", DIST_W'(seen_report.stop_flag),
                                DIST_W'(result_bus.stop_flag));
                    check_field("emergency_flag", DIST_W'(seen_report.emergency_flag),
                                DIST_W'(result_bus.emergency_flag));
                    check_field("disarm_request", DIST_W'(seen_report.disarm_request),
                                DIST_W'(result_bus.disarm_request));
                    check_field("stop_event", DIST_W'(seen_report.stop_event),
                                DIST_W'(result_bus.stop_event));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic wait_drained();
        do
            @(negedge clk);
        while (echo_backlog.size() != 0 || item_bus.valid || predicted_reports.size() != 0);
    endtask

    task automatic write_reg(ecss_pkg::reg_index_t idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        case (idx)
            ecss_pkg::REG_SENSOR_ENABLED: cfg_enabled = val[0];
            ecss_pkg::REG_WARN_DISTANCE:  warn_mm     = val[DIST_W-1:0];
            ecss_pkg::REG_STOP_DISTANCE:  stop_mm     = val[DIST_W-1:0];
            ecss_pkg::REG_EMERG_DISTANCE: emerg_mm    = val[DIST_W-1:0];
            ecss_pkg::REG_CLEAR_MARGIN:   margin_mm   = val[DIST_W-1:0];
            ecss_pkg::REG_DANGER_CONFIRM: danger_need = val[CONFIRM_W-1:0];
            ecss_pkg::REG_CLEAR_CONFIRM:  clear_need  = val[CONFIRM_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(logic en, int warn, int stop, int emerg, int margin,
                                  int dneed, int cneed);
        write_reg(ecss_pkg::REG_SENSOR_ENABLED, CFG_DATA_W'(en));
        write_reg(ecss_pkg::REG_WARN_DISTANCE, CFG_DATA_W'(warn));
        write_reg(ecss_pkg::REG_STOP_DISTANCE, CFG_DATA_W'(stop));
        write_reg(ecss_pkg::REG_EMERG_DISTANCE, CFG_DATA_W'(emerg));
        write_reg(ecss_pkg::REG_CLEAR_MARGIN, CFG_DATA_W'(margin));
        write_reg(ecss_pkg::REG_DANGER_CONFIRM, CFG_DATA_W'(dneed));
        write_reg(ecss_pkg::REG_CLEAR_CONFIRM, CFG_DATA_W'(cneed));
    endtask

    task automatic push_word(ecss_pkg::opcode_t op, logic [WIDTH_US_W-1:0] width_us,
                             logic armed);
        echo_word_t w;
        w.op       = op;
        w.width_us = width_us;
        w.armed    = armed;
        echo_backlog.push_back(w);
    endtask

    // smallest width that converts to mm, plus a rounding jitter
    task automatic push_echo(int mm, int jitter, logic armed);
        int wv;
        wv = (mm * SOUND_DEN + SOUND_NUM - 1) / SOUND_NUM + jitter;
        if (wv > 65535)
            wv = 65535;
        push_word(ecss_pkg::OP_ECHO, WIDTH_US_W'(wv), armed);
    endtask

    // runs of words aimed at one distance band so the counters can build up
    task automatic queue_random_phase(int count);
        int queued;
        int regime;
        int run_len;
        int mm;
        int lo;
        queued = 0;
        while (queued < count)
        begin
            regime  = int'($urandom_range(0, 9));
            run_len = int'($urandom_range(1, 24));
            repeat (run_len)
            begin
                case (regime)
                    0, 8: mm = int'($urandom_range(LO_MM, int'(stop_mm)));
                    1, 9:
                    begin
                        lo = int'(stop_mm) + int'(margin_mm) + 1;
                        mm = (lo > HI_MM) ? int'($urandom_range(LO_MM, HI_MM))
                                          : int'($urandom_range(lo, HI_MM));
                    end
                    2: mm = int'($urandom_range(int'(stop_mm) + 1,
                                                int'(stop_mm) + int'(margin_mm)));
                    3: mm = int'($urandom_range(LO_MM, int'(emerg_mm)));
                    4:
                    begin
                        case ($urandom_range(0, 11))
                            0:  mm = LO_MM - 1;
                            1:  mm = LO_MM;
                            2:  mm = HI_MM;
                            3:  mm = HI_MM + 1;
                            4:  mm = int'(warn_mm);
                            5:  mm = int'(warn_mm) + 1;
                            6:  mm = int'(stop_mm);
                            7:  mm = int'(stop_mm) + 1;
                            8:  mm = int'(emerg_mm);
                            9:  mm = int'(emerg_mm) + 1;
                            10: mm = int'(stop_mm) + int'(margin_mm);
                            default: mm = int'(stop_mm) + int'(margin_mm) + 1;
                        endcase
                    end
                    default: mm = int'($urandom_range(LO_MM, HI_MM));
                endcase
                if (regime == 5 || $urandom_range(0, 12) == 0)
                    push_word(ecss_pkg::OP_TIMEOUT, WIDTH_US_W'($urandom),
                              1'($urandom_range(0, 1)));
                else if (regime == 6)
                    push_word(ecss_pkg::OP_ECHO, WIDTH_US_W'($urandom),
                              1'($urandom_range(0, 1)));
                else
                    push_echo(mm, (regime == 4) ? 0 : int'($urandom_range(0, 5)),
                              1'($urandom_range(0, 1)));
                queued++;
            end
            if ($urandom_range(0, 15) == 0)
                wait_drained();
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = ecss_pkg::REG_SENSOR_ENABLED;
        cfg_bus.data  = '0;
        cfg_enabled = ecss_pkg::RST_SENSOR_ENABLED;
        warn_mm     = ecss_pkg::RST_WARN_DISTANCE;
        stop_mm     = ecss_pkg::RST_STOP_DISTANCE;
        emerg_mm    = ecss_pkg::RST_EMERG_DISTANCE;
        margin_mm   = ecss_pkg::RST_CLEAR_MARGIN;
        danger_need = ecss_pkg::RST_DANGER_CONFIRM;
        clear_need  = ecss_pkg::RST_CLEAR_CONFIRM;
        danger_run  = 0;
        clear_run   = 0;
        stop_held   = 1'b0;
        emerg_held  = 1'b0;
        reading_ok  = 1'b0;
        near_held   = 1'b0;
        event_sent  = 1'b0;
        last_mm     = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed words at the reset settings
        push_word(ecss_pkg::OP_ECHO, 16'h0000, 1'b1);
        push_word(ecss_pkg::OP_ECHO, 16'hFFFF, 1'b0);
        push_word(ecss_pkg::OP_TIMEOUT, 16'hFFFF, 1'b1);
        push_echo(LO_MM - 1, 0, 1'b1);
        push_echo(LO_MM, 0, 1'b1);
        push_echo(HI_MM, 0, 1'b0);
        push_echo(HI_MM + 1, 0, 1'b1);
        push_echo(600, 0, 1'b0);
        push_echo(601, 0, 1'b0);
        push_echo(300, 0, 1'b1);
        push_echo(300, 0, 1'b1);
        push_echo(200, 0, 1'b0);
        push_word(ecss_pkg::OP_TIMEOUT, 16'h0000, 1'b1);
        push_echo(400, 0, 1'b1);
        push_echo(300, 0, 1'b1);
        repeat (3) push_echo(1000, 0, 1'b1);
        push_echo(300, 0, 1'b1);
        push_echo(250, 0, 1'b1);
        wait_drained();
        write_reg(ecss_pkg::REG_SENSOR_ENABLED, '0);
        push_echo(300, 0, 1'b1);
        push_word(ecss_pkg::OP_TIMEOUT, 16'h5A5A, 1'b1);
        push_echo(1000, 0, 1'b0);
        wait_drained();

        for (int p = 0; p < 10; p++)
        begin
            case (p)
                0: apply_settings(1'b1, 600, 350, 250, 150, 2, 3);
                1: apply_settings(1'b1, 0, 0, 0, 0, 0, 0);
                2: apply_settings(1'b1, 4000, 4000, 4000, 4000, 255, 255);
                3: apply_settings(1'b1, 2000, 1000, 800, 500, COUNT_CAP, COUNT_CAP);
                4: apply_settings(1'b1, 1500, 700, 400, 0, 1, 1);
                5: apply_settings(1'b1, 900, 600, 300, 4000, 1, 0);
                6: apply_settings(1'b0, 600, 350, 250, 150, 2, 3);
                default: apply_settings(1'b1, int'($urandom_range(0, 4000)),
                                        int'($urandom_range(150, 2500)),
                                        int'($urandom_range(0, 2500)),
                                        int'($urandom_range(0, 1500)),
                                        int'($urandom_range(0, 24)),
                                        int'($urandom_range(0, 24)));
            endcase
            queue_random_phase(PHASE_WORDS);
            wait_drained();
        end

        repeat (20) @(negedge clk);
        if (mismatches == 0 && predicted_reports.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
